@@ design/h263fbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package h263fbm_pkg;

  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       packet_start;
    logic       packet_end;
    logic       frame_end;
    logic [2:0] start_bits;
    logic [2:0] end_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  function automatic logic [7:0] low_mask(input logic [2:0] sbits);
    low_mask = 8'hff >> sbits;
  endfunction

  function automatic logic [7:0] high_mask(input logic [2:0] ebits);
    high_mask = 8'hff << ebits;
  endfunction

endpackage
`default_nettype wire

@@ design/h263fbm_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
module h263fbm_merge
  import h263fbm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire in_item_t item,
  output push_t         push
);

  logic [7:0] pending_byte;
  logic       pending_valid;
  logic [7:0] pending_byte_next;
  logic       pending_valid_next;

  logic       merge;
  logic       end_mask;
  logic [7:0] end_and;
  logic [7:0] byte_mid;
  logic       valid_mid;
  logic       emit_append;
  logic       emit_end;

  always_comb begin
    merge    = item.mode && item.packet_start && (item.start_bits != 3'd0);
    end_mask = item.mode && item.packet_end && (item.end_bits != 3'd0);
    end_and  = end_mask ? high_mask(item.end_bits) : 8'hff;

    if (merge) begin
      valid_mid = pending_valid;
      byte_mid  = pending_valid
                ? ((pending_byte | (item.in_byte & low_mask(item.start_bits))) & end_and)
                : pending_byte;
    end else begin
      valid_mid = 1'b1;
      byte_mid  = item.in_byte & end_and;
    end

    emit_append = !merge && pending_valid;
    emit_end    = item.frame_end && valid_mid;

    push.count  = step ? ({1'b0, emit_append} + {1'b0, emit_end}) : 2'd0;
    push.first  = emit_append ? out_item_t'{out_byte: pending_byte, last_of_frame: 1'b0}
                              : out_item_t'{out_byte: byte_mid, last_of_frame: 1'b1};
    push.second = out_item_t'{out_byte: byte_mid, last_of_frame: 1'b1};

    if (item.frame_end) begin
      pending_byte_next  = 8'h00;
      pending_valid_next = 1'b0;
    end else begin
      pending_byte_next  = byte_mid;
      pending_valid_next = valid_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte  <= 8'h00;
      pending_valid <= 1'b0;
    end else if (step) begin
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
    end
  end

endmodule
`default_nettype wire

@@ design/h263fbm_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module h263fbm_out_queue
  import h263fbm_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire push_t     push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  out_item_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_second;
  logic          pop;

  assign wr_ptr_second = wr_ptr + PW'(1);
  assign pop           = out_valid && out_ready;
  assign out_valid     = (count != '0);
  assign out_data      = entries[rd_ptr];
  assign room          = (count <= ROOM_MAX);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/h263_fragment_bit_merge_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake            | word
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | in_data: mode, byte, packet flags, counts
// output   | out_valid / out_ready| out_data: out_byte, last_of_frame
//
// One input word per cycle while the queue has room. A word is held in the input register, then
// the pending-byte merge puts 0, 1 or 2 words into a DEPTH-entry output queue.
// Output words are read only from the output queue, after they are registered there.
// The input register advances only while the queue has room for two words.
// Synchronous reset clears the pending byte, the input register and the queue.
module h263_fragment_bit_merge_core
  import h263fbm_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic     stage_valid;
  in_item_t stage_item;
  logic     room;
  logic     advance;
  push_t    push;

  assign advance  = stage_valid && room;
  assign in_ready = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  h263fbm_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (stage_item),
    .push (push)
  );

  h263fbm_out_queue #(
    .DEPTH (DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
